>>> hdl/macpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving-average crossover tracker package
// Shared sizes, fixed-point constants and codes for the crossover tracker.
// ----------------------------------------------------------------------------
package macpt_pkg;

  // History and warm-up sizing.
  localparam int WARMUP_BARS = 30;
  localparam int HIST_DEPTH  = 32;
  localparam int SLOT_W      = $clog2(HIST_DEPTH);
  localparam int LEN_LIM     = (WARMUP_BARS < HIST_DEPTH) ? WARMUP_BARS : HIST_DEPTH;
  localparam int LEN_W       = $clog2(LEN_LIM + 1);
  localparam int BAR_W       = $clog2(WARMUP_BARS + 2);

  // Fixed-point constants (Q.24).
  localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
  localparam logic signed [31:0] MIN_EQUITY  = 32'sd1677722;
  localparam logic [12:0]        FEE_PER_LEV = 13'd6711;
  localparam logic [63:0]        QUOT_CAP    = 64'h0080_0000_0000_0000;

  // Configuration register indexes.
  localparam logic [2:0] REG_FAST_LEN  = 3'd0;
  localparam logic [2:0] REG_SLOW_LEN  = 3'd1;
  localparam logic [2:0] REG_OPEN_THR  = 3'd2;
  localparam logic [2:0] REG_CLOSE_THR = 3'd3;
  localparam logic [2:0] REG_LEVERAGE  = 3'd4;
  localparam logic [2:0] REG_STOP_LIM  = 3'd5;

  // Position modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_LONG  = 2'd1;
  localparam logic [1:0] MODE_SHORT = 2'd2;

  // Bar events.
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_OPEN_LONG  = 3'd1;
  localparam logic [2:0] EV_OPEN_SHORT = 3'd2;
  localparam logic [2:0] EV_CROSS      = 3'd3;
  localparam logic [2:0] EV_STOP       = 3'd4;
  localparam logic [2:0] EV_HALT       = 3'd5;
  localparam logic [2:0] EV_REOPEN     = 3'd6;

  // Effective average length: zero acts as one, long values are clipped.
  function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] v);
    if (32'(v) > LEN_LIM) begin
      return LEN_W'(LEN_LIM);
    end else if (v == 5'd0) begin
      return LEN_W'(1);
    end else begin
      return LEN_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/macpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module macpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/ma_crossover_position_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving-average crossover position tracker
// Tracks an idle, long or short position over price bars from the fast and
// slow averages of past closes, with stop loss, fees and a halting floor.
// ----------------------------------------------------------------------------
//  Channel  Handshake                Carries
//  in       in_valid / in_ready      open, high, low, close prices, last_bar
//  out      out_valid / out_ready    equity, position_mode, bar_event, halted,
//                                    final_result
//  cfg      cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
//  Warm-up bars pass ST_FINISH and ST_DONE, bars after a halt go straight to ST_DONE;
//  both then wait on out_ready in ST_OUT. A trading bar walks the close history one
//  entry per ST_SUM_ADDR/ST_SUM_DATA pass (the larger effective length), then runs a
//  shared 33x33 multiplier and a 64-step restoring divider.
//  One item is in work at a time; in_ready is low until the result is taken.
//  Reset clears the run state; the history memory is written before it is read.
// ----------------------------------------------------------------------------
module ma_crossover_position_tracker
  import macpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        open_price,
  input  wire logic [31:0]        high_price,
  input  wire logic [31:0]        low_price,
  input  wire logic [31:0]        close_price,
  input  wire logic               last_bar,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      equity,
  output logic [1:0]              position_mode,
  output logic [2:0]              bar_event,
  output logic                    halted,
  output logic                    final_result
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUM_ADDR, ST_SUM_DATA, ST_D_PROD, ST_D_DIFF, ST_T_CLOSE,
    ST_POS_NUM, ST_POS_CMP, ST_DIV, ST_DIV_END, ST_MS_LO, ST_MS_HI, ST_MS_FIN,
    ST_OPEN_CHK, ST_HALT_CHK, ST_FINISH, ST_DONE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_CLOSE1, PH_CLOSE2, PH_HOLD, PH_OPEN, PH_HALT
  } phase_t;

  state_t state;
  phase_t phase;

  // Configuration registers.
  logic [4:0]         fast_len, slow_len;
  logic [15:0]        open_thr, close_thr;
  logic [6:0]         lev;
  logic signed [16:0] stop_lim;

  // Run state.
  logic [SLOT_W-1:0]  slot;
  logic [BAR_W-1:0]   bar_index;
  logic [1:0]         mode;
  logic [31:0]        entry_price;
  logic signed [31:0] entry_equity;
  logic signed [31:0] running_equity;
  logic               stopped;

  // Latched item.
  logic [31:0] price, hi_q, lo_q, cl_q;
  logic        last_q;

  // Working registers.
  logic [LEN_W-1:0]   k;
  logic [36:0]        fast_sum, slow_sum;
  logic [31:0]        prev;
  logic [42:0]        fls, slf;
  logic [11:0]        lfls;
  logic signed [59:0] d;
  logic [59:0]        t_open, t_close;
  logic signed [40:0] num, worst_l;
  logic [63:0]        dvd;
  logic [31:0]        rem;
  logic [5:0]         div_cnt;
  logic               div_neg, div_close;
  logic signed [56:0] fac, ms_b, sec_fac;
  logic signed [31:0] ms_a;
  logic [63:0]        p_lo;
  logic               closed;
  logic [2:0]         event_q;
  logic signed [65:0] mul_p;

  // Effective lengths and derived factors.
  logic [LEN_W-1:0]   lf, ls, kmax;
  logic [19:0]        lev_fee;
  logic signed [56:0] fee_q, stop_q;
  logic signed [17:0] stop_sum;

  assign lf      = eff_len(fast_len);
  assign ls      = eff_len(slow_len);
  assign kmax    = (lf > ls) ? lf : ls;
  assign lev_fee = 20'(lev) * 20'(FEE_PER_LEV);
  assign fee_q   = 57'sd16777216 - $signed({37'd0, lev_fee});
  assign stop_sum = 18'sd65536 + 18'(stop_lim);
  assign stop_q  = 57'(stop_sum) <<< 8;

  // History memory.
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [31:0]          ram_rdata;
  logic [SLOT_W+1:0]    addr_tmp;

  always_comb begin
    addr_tmp = (SLOT_W+2)'(slot) + (SLOT_W+2)'(HIST_DEPTH) - (SLOT_W+2)'(k);
    if (addr_tmp >= (SLOT_W+2)'(HIST_DEPTH)) begin
      addr_tmp = addr_tmp - (SLOT_W+2)'(HIST_DEPTH);
    end
    ram_raddr = addr_tmp[SLOT_W-1:0];
  end

  assign ram_we = (state == ST_FINISH) && !stopped;

  macpt_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (cl_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier: operands chosen by the sequencer step.
  logic [31:0]        ms_ua;
  logic [55:0]        ms_ub;
  logic [56:0]        nb;
  logic               ms_neg;
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] mul_full;

  always_comb begin
    nb     = 57'(-ms_b);
    ms_ua  = ms_a[31] ? 32'(-ms_a) : 32'(ms_a);
    ms_ub  = ms_b[56] ? nb[55:0] : ms_b[55:0];
    ms_neg = ms_a[31] != ms_b[56];
    mul_x  = '0;
    mul_y  = '0;
    case (state)
      ST_D_PROD: begin
        mul_x = {1'b0, prev};
        mul_y = {17'd0, open_thr};
      end
      ST_D_DIFF: begin
        mul_x = {1'b0, prev};
        mul_y = {17'd0, close_thr};
      end
      ST_POS_NUM: begin
        mul_x = 33'(stop_lim);
        mul_y = {1'b0, entry_price};
      end
      ST_MS_LO: begin
        mul_x = {1'b0, ms_ua};
        mul_y = {9'd0, ms_ub[23:0]};
      end
      ST_MS_HI: begin
        mul_x = {1'b0, ms_ua};
        mul_y = {1'b0, ms_ub[55:24]};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    mul_full = mul_x * mul_y;
  end

  // Saturating multiply result.
  logic [64:0]        ms_m;
  logic signed [31:0] ms_res;

  always_comb begin
    ms_m = 65'(mul_p[63:0]) + 65'(p_lo >> 24);
    if (!ms_neg) begin
      ms_res = (ms_m > 65'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(ms_m[31:0]);
    end else begin
      ms_res = (ms_m >= 65'h8000_0000) ? 32'sh8000_0000 : $signed(32'(-ms_m[31:0]));
    end
  end

  // Divider step.
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [63:0] quot_next, quot_cap;

  always_comb begin
    rem_sh    = {rem, dvd[63]};
    div_ge    = rem_sh >= {1'b0, entry_price};
    quot_next = {dvd[62:0], div_ge};
    quot_cap  = (quot_next >= QUOT_CAP) ? QUOT_CAP : quot_next;
  end

  // Position comparisons.
  logic               is_short;
  logic signed [32:0] move_s, worst_s;
  logic signed [63:0] d64, t_close64, t_open64, ad64;
  logic signed [65:0] worst_ext;
  logic               close_hit, stop_hit;
  logic [39:0]        num_mag;

  always_comb begin
    is_short  = mode == MODE_SHORT;
    move_s    = is_short ? ($signed({1'b0, entry_price}) - $signed({1'b0, price}))
                         : ($signed({1'b0, price}) - $signed({1'b0, entry_price}));
    worst_s   = is_short ? ($signed({1'b0, entry_price}) - $signed({1'b0, hi_q}))
                         : ($signed({1'b0, lo_q}) - $signed({1'b0, entry_price}));
    d64       = 64'(d);
    t_close64 = $signed({4'd0, t_close});
    t_open64  = $signed({4'd0, t_open});
    ad64      = d64[63] ? -d64 : d64;
    close_hit = is_short ? (d64 > t_close64) : (-d64 > t_close64);
    worst_ext = $signed({{9{worst_l[40]}}, worst_l, 16'd0});
    stop_hit  = (entry_price != 32'd0) && (worst_ext <= mul_p);
    num_mag   = num[40] ? 40'(-num) : 40'(num);
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = state == ST_IDLE;
  assign out_valid = state == ST_OUT;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_len  <= 5'd5;
      slow_len  <= 5'd10;
      open_thr  <= 16'd26;
      close_thr <= 16'd13;
      lev       <= 7'd1;
      stop_lim  <= -17'sd6554;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FAST_LEN:  fast_len  <= cfg_data[4:0];
        REG_SLOW_LEN:  slow_len  <= cfg_data[4:0];
        REG_OPEN_THR:  open_thr  <= cfg_data[15:0];
        REG_CLOSE_THR: close_thr <= cfg_data[15:0];
        REG_LEVERAGE:  lev       <= cfg_data[6:0];
        REG_STOP_LIM:  stop_lim  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer, run state and result registers.
  always_ff @(posedge clk) begin
    mul_p <= mul_full;
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_HOLD;
      slot           <= '0;
      bar_index      <= '0;
      mode           <= MODE_IDLE;
      entry_price    <= '0;
      entry_equity   <= '0;
      running_equity <= ONE_Q24;
      stopped        <= 1'b0;
      fast_sum       <= '0;
      slow_sum       <= '0;
      equity         <= '0;
      position_mode  <= MODE_IDLE;
      bar_event      <= EV_NONE;
      halted         <= 1'b0;
      final_result   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            price   <= 32'((34'(open_price) + 34'(high_price) + 34'(low_price)
                        + 34'(close_price)) >> 2);
            hi_q    <= high_price;
            lo_q    <= low_price;
            cl_q    <= close_price;
            last_q  <= last_bar;
            event_q <= EV_NONE;
            closed  <= 1'b0;
            if (stopped) begin
              state <= ST_DONE;
            end else if (32'(bar_index) <= WARMUP_BARS) begin
              state <= ST_FINISH;
            end else begin
              k        <= LEN_W'(1);
              fast_sum <= '0;
              slow_sum <= '0;
              state    <= ST_SUM_ADDR;
            end
          end
        end
        // Walk back through the history, one entry per pass through the address and data states.
        ST_SUM_ADDR: state <= ST_SUM_DATA;
        ST_SUM_DATA: begin
          if (k <= lf) fast_sum <= fast_sum + 37'(ram_rdata);
          if (k <= ls) slow_sum <= slow_sum + 37'(ram_rdata);
          if (k == LEN_W'(1)) prev <= ram_rdata;
          if (k == kmax) begin
            state <= ST_D_PROD;
          end else begin
            k     <= k + LEN_W'(1);
            state <= ST_SUM_ADDR;
          end
        end
        // Average gap and thresholds, all scaled by both lengths.
        ST_D_PROD: begin
          fls   <= 43'(fast_sum) * 43'(ls);
          slf   <= 43'(slow_sum) * 43'(lf);
          lfls  <= 12'(lf) * 12'(ls);
          state <= ST_D_DIFF;
        end
        ST_D_DIFF: begin
          d      <= 60'($signed({1'b0, fls}) - $signed({1'b0, slf})) <<< 16;
          t_open <= 60'(mul_p[47:0]) * 60'(lfls);
          state  <= ST_T_CLOSE;
        end
        ST_T_CLOSE: begin
          t_close <= 60'(mul_p[47:0]) * 60'(lfls);
          state   <= (mode != MODE_IDLE) ? ST_POS_NUM : ST_OPEN_CHK;
        end
        // Open position: profit numerator, worst move and stop bound.
        ST_POS_NUM: begin
          num     <= 41'($signed({1'b0, entry_price})) + 41'(move_s) * $signed({34'd0, lev});
          worst_l <= 41'(worst_s) * $signed({34'd0, lev});
          state   <= ST_POS_CMP;
        end
        ST_POS_CMP: begin
          div_neg <= num[40];
          dvd     <= {num_mag, 24'd0};
          rem     <= '0;
          div_cnt <= '0;
          if (close_hit) begin
            event_q   <= EV_CROSS;
            div_close <= 1'b1;
            if (entry_price == 32'd0) begin
              fac   <= 57'(ONE_Q24);
              state <= ST_DIV_END;
            end else begin
              state <= ST_DIV;
            end
          end else if (stop_hit) begin
            event_q <= EV_STOP;
            ms_a    <= entry_equity;
            ms_b    <= fee_q;
            sec_fac <= stop_q;
            phase   <= PH_CLOSE1;
            state   <= ST_MS_LO;
          end else begin
            div_close <= 1'b0;
            if (entry_price == 32'd0) begin
              fac   <= 57'(ONE_Q24);
              state <= ST_DIV_END;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        // Restoring division, one quotient bit per cycle.
        ST_DIV: begin
          rem     <= div_ge ? 32'(rem_sh - {1'b0, entry_price}) : rem_sh[31:0];
          dvd     <= quot_next;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) begin
            fac   <= div_neg ? -$signed(57'(quot_cap)) : $signed(57'(quot_cap));
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          ms_a <= entry_equity;
          if (div_close) begin
            ms_b    <= fee_q;
            sec_fac <= fac;
            phase   <= PH_CLOSE1;
          end else begin
            ms_b  <= fac;
            phase <= PH_HOLD;
          end
          state <= ST_MS_LO;
        end
        // Saturating equity multiply through ST_MS_LO, ST_MS_HI and ST_MS_FIN.
        ST_MS_LO: state <= ST_MS_HI;
        ST_MS_HI: begin
          p_lo  <= mul_p[63:0];
          state <= ST_MS_FIN;
        end
        ST_MS_FIN: begin
          unique case (phase)
            PH_CLOSE1: begin
              ms_a  <= ms_res;
              ms_b  <= sec_fac;
              phase <= PH_CLOSE2;
              state <= ST_MS_LO;
            end
            PH_CLOSE2: begin
              running_equity <= ms_res;
              mode           <= MODE_IDLE;
              closed         <= 1'b1;
              state          <= ST_OPEN_CHK;
            end
            PH_HOLD: begin
              running_equity <= ms_res;
              state          <= ST_OPEN_CHK;
            end
            PH_OPEN: begin
              running_equity <= ms_res;
              entry_equity   <= ms_res;
              entry_price    <= price;
              mode           <= d[59] ? MODE_SHORT : MODE_LONG;
              event_q        <= closed ? EV_REOPEN : (d[59] ? EV_OPEN_SHORT : EV_OPEN_LONG);
              state          <= ST_HALT_CHK;
            end
            PH_HALT: begin
              running_equity <= ms_res;
              state          <= ST_FINISH;
            end
            default: state <= ST_FINISH;
          endcase
        end
        // Open a new position on a wide enough gap.
        ST_OPEN_CHK: begin
          if (mode == MODE_IDLE && ad64 > t_open64) begin
            ms_a  <= running_equity;
            ms_b  <= fee_q;
            phase <= PH_OPEN;
            state <= ST_MS_LO;
          end else begin
            state <= ST_HALT_CHK;
          end
        end
        // Halt once equity is below the floor; an open position pays a fee.
        ST_HALT_CHK: begin
          if (running_equity < MIN_EQUITY) begin
            stopped <= 1'b1;
            event_q <= EV_HALT;
            if (mode != MODE_IDLE) begin
              ms_a  <= running_equity;
              ms_b  <= fee_q;
              phase <= PH_HALT;
              state <= ST_MS_LO;
            end else begin
              state <= ST_FINISH;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        // Store the close and advance the ring.
        ST_FINISH: begin
          if (!stopped) begin
            slot <= (slot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
            if (32'(bar_index) <= WARMUP_BARS) bar_index <= bar_index + BAR_W'(1);
          end
          state <= ST_DONE;
        end
        // Register the result; the last bar restarts the run.
        ST_DONE: begin
          equity        <= running_equity;
          position_mode <= mode;
          bar_event     <= event_q;
          halted        <= stopped;
          final_result  <= last_q;
          if (last_q) begin
            slot           <= '0;
            bar_index      <= '0;
            mode           <= MODE_IDLE;
            entry_price    <= '0;
            entry_equity   <= '0;
            running_equity <= ONE_Q24;
            stopped        <= 1'b0;
            fast_sum       <= '0;
            slow_sum       <= '0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_halt_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bar_event == EV_HALT) |-> halted)
    else $error("halt event without halted flag");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (entry_price != 32'd0))
    else $error("division by a zero entry price");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position_mode != 2'd3))
    else $error("position mode out of range");

  a_open_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (bar_event == EV_OPEN_LONG)) |-> (position_mode == MODE_LONG))
    else $error("long opened but mode differs");

endmodule
`default_nettype wire
